// File: sv/parc_pkg.sv
`timescale 1ns / 1ps
package parc_pkg;
  localparam int AngW = 16;
  localparam int ZW = 20;
  localparam int XW = 19;
  localparam int TcW = 16;
  localparam int LimW = 15;
  localparam int ErrW = 17;
  localparam int EulW = 24;
  localparam int QW = 30;
  localparam int RegFloor = 41;
  localparam int TcReset = 2048;
  localparam int LimReset = 4289;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_TC = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DN = 2'd2;
  localparam logic signed [ZW-1:0] Q16Pi = 20'sd205887;
  localparam logic signed [ZW-1:0] Q16HalfPi = 20'sd102944;
  localparam logic signed [XW-1:0] CordicGain = 19'sd39797;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 20'sd51472;
        1: r = 20'sd30386;
        2: r = 20'sd16055;
        3: r = 20'sd8150;
        4: r = 20'sd4091;
        5: r = 20'sd2047;
        6: r = 20'sd1024;
        7: r = 20'sd512;
        8: r = 20'sd256;
        9: r = 20'sd128;
        10: r = 20'sd64;
        11: r = 20'sd32;
        12: r = 20'sd16;
        13: r = 20'sd8;
        14: r = 20'sd4;
        15: r = 20'sd2;
        16: r = 20'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // per-cell sideband carried along the chain
  typedef struct packed {
    logic signed [AngW-1:0] yaw;
    logic signed [EulW-1:0] euler;
    logic [LimW-1:0] hi;
    logic [LimW-1:0] lo;
  } side_t;
endpackage

// File: sv/parc_if.sv
`timescale 1ns / 1ps
interface parc_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] pitch_target;
  logic signed [15:0] roll_angle;
  logic signed [15:0] yaw_rate;
  modport source(output valid, pitch_angle, pitch_target, roll_angle, yaw_rate, input ready);
  modport sink(input valid, pitch_angle, pitch_target, roll_angle, yaw_rate, output ready);
endinterface

interface parc_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] body_pitch_rate;
  logic signed [23:0] euler_pitch_rate;
  modport source(output valid, body_pitch_rate, euler_pitch_rate, input ready);
  modport sink(input valid, body_pitch_rate, euler_pitch_rate, output ready);
endinterface

// File: sv/parc_div_cell.sv
`timescale 1ns / 1ps
// one restoring-division step: remainder vs divisor shifted by STEP
module parc_div_cell
  import parc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [QW+TcW:0]   rem_i,
  input  logic [QW-1:0]     q_i,
  input  logic [TcW:0]      d_i,
  output logic [QW+TcW:0]   rem_o,
  output logic [QW-1:0]     q_o
);
  logic [QW+TcW:0] rem_r, trial;
  logic [QW-1:0] q_r;
  logic ge;
  assign trial = {{QW{1'b0}}, d_i} << STEP;
  assign ge = rem_i >= trial;
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? rem_i - trial : rem_i;
      q_r <= q_i | (QW'(ge) << STEP);
    end
  end
  assign rem_o = rem_r;
  assign q_o = q_r;
endmodule

// File: sv/parc_cordic_cell.sv
`timescale 1ns / 1ps
// one CORDIC rotation stage for two angles side by side
module parc_cordic_cell
  import parc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [XW-1:0] rx_i, ry_i, px_i, py_i,
  input  logic signed [ZW-1:0] rz_i, pz_i,
  output logic signed [XW-1:0] rx_o, ry_o, px_o, py_o,
  output logic signed [ZW-1:0] rz_o, pz_o
);
  logic signed [XW-1:0] rx_r, ry_r, px_r, py_r;
  logic signed [ZW-1:0] rz_r, pz_r;
  localparam logic signed [ZW-1:0] At = atan_q16(STEP);
  always_ff @(posedge clk) begin
    if (en) begin
      if (!rz_i[ZW-1]) begin
        rx_r <= rx_i - (ry_i >>> STEP); ry_r <= ry_i + (rx_i >>> STEP); rz_r <= rz_i - At;
      end else begin
        rx_r <= rx_i + (ry_i >>> STEP); ry_r <= ry_i - (rx_i >>> STEP); rz_r <= rz_i + At;
      end
      if (!pz_i[ZW-1]) begin
        px_r <= px_i - (py_i >>> STEP); py_r <= py_i + (px_i >>> STEP); pz_r <= pz_i - At;
      end else begin
        px_r <= px_i + (py_i >>> STEP); py_r <= py_i - (px_i >>> STEP); pz_r <= pz_i + At;
      end
    end
  end
  assign rx_o = rx_r; assign ry_o = ry_r; assign rz_o = rz_r;
  assign px_o = px_r; assign py_o = py_r; assign pz_o = pz_r;
endmodule

// File: sv/pitch_attitude_rate_command.sv
`timescale 1ns / 1ps
// Channel | Dir | Word
// in_     | in  | pitch_angle, pitch_target, roll_angle, yaw_rate
// out_    | out | body_pitch_rate, euler_pitch_rate
// cfg_    | in  | we, idx, data (time constant, nose-up, nose-down limits)
// One word per cycle unless out_ready stalls; capture register, divider cell row (one
// quotient bit per cell), CORDIC cell row, product registers and output register in turn.
// The whole chain advances when the output register is empty or being taken;
// a stall on out_ready freezes every cell. Reset clears valid bits and loads config defaults.
module pitch_attitude_rate_command
  import parc_pkg::*;
#(
  parameter int CORDIC_STAGES = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  parc_in_if.sink             in_ch,
  parc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);
  localparam int NS = CORDIC_STAGES;
  localparam int DL = QW + 1;          // capture stage plus divider cells
  localparam int NL = DL + NS + 4;     // total valid chain

  logic [TcW-1:0] tc_r;
  logic [LimW-1:0] up_r, dn_r;
  logic [NL-1:0] vld_r;
  logic en;

  // config with floor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TcW'(TcReset); up_r <= LimW'(LimReset); dn_r <= LimW'(LimReset);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TC: tc_r <= (cfg_data < CfgDataW'(RegFloor)) ? TcW'(RegFloor) : cfg_data;
        CFG_UP: up_r <= (cfg_data[LimW-1:0] < LimW'(RegFloor)) ? LimW'(RegFloor)
                        : cfg_data[LimW-1:0];
        CFG_DN: dn_r <= (cfg_data[LimW-1:0] < LimW'(RegFloor)) ? LimW'(RegFloor)
                        : cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NL-2:0], in_ch.valid};
  end

  // stage 0: capture, error magnitude, numerator mag*4096+tc, divisor 2tc
  logic [QW+TcW:0] rem0_r;
  logic [TcW:0] d0_r;
  logic neg0_r;
  logic signed [AngW-1:0] pa0_r, ra0_r, ya0_r;
  logic [LimW-1:0] hi0_r, lo0_r;
  logic signed [ErrW-1:0] err;
  logic [ErrW-1:0] mag;
  assign err = ErrW'(in_ch.pitch_target) - ErrW'(in_ch.pitch_angle);
  assign mag = err[ErrW-1] ? ErrW'(-err) : err;
  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= (QW+TcW+1)'({mag, 12'b0}) + (QW+TcW+1)'(tc_r);
      d0_r <= {tc_r, 1'b0};
      neg0_r <= err[ErrW-1];
      pa0_r <= in_ch.pitch_angle; ra0_r <= in_ch.roll_angle; ya0_r <= in_ch.yaw_rate;
      hi0_r <= up_r; lo0_r <= dn_r;
    end
  end

  // divider cell row, MSB first; angles ride along in delay line
  logic [QW+TcW:0] rem_c [QW+1];
  logic [QW-1:0] q_c [QW+1];
  logic signed [AngW-1:0] pa_d [QW+1], ra_d [QW+1], ya_d [QW+1];
  logic neg_d [QW+1];
  logic [LimW-1:0] hi_d [QW+1], lo_d [QW+1];
  logic [TcW:0] dv_d [QW+1];
  assign rem_c[0] = rem0_r; assign q_c[0] = '0; assign dv_d[0] = d0_r;
  assign pa_d[0] = pa0_r; assign ra_d[0] = ra0_r; assign ya_d[0] = ya0_r;
  assign neg_d[0] = neg0_r; assign hi_d[0] = hi0_r; assign lo_d[0] = lo0_r;
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic signed [AngW-1:0] pa_r, ra_r, ya_r;
    logic neg_r;
    logic [LimW-1:0] hi_r, lo_r;
    logic [TcW:0] dv_r;
    parc_div_cell #(.STEP(QW-1-k)) u_cell (
      .clk(clk), .en(en), .rem_i(rem_c[k]), .q_i(q_c[k]), .d_i(dv_d[k]),
      .rem_o(rem_c[k+1]), .q_o(q_c[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        pa_r <= pa_d[k]; ra_r <= ra_d[k]; ya_r <= ya_d[k];
        neg_r <= neg_d[k]; hi_r <= hi_d[k]; lo_r <= lo_d[k]; dv_r <= dv_d[k];
      end
    end
    assign pa_d[k+1] = pa_r; assign ra_d[k+1] = ra_r; assign ya_d[k+1] = ya_r;
    assign neg_d[k+1] = neg_r; assign hi_d[k+1] = hi_r; assign lo_d[k+1] = lo_r;
    assign dv_d[k+1] = dv_r;
  end

  // sign, saturate, and quadrant-reduce both angles into CORDIC start
  logic signed [QW:0] qs;
  logic signed [EulW-1:0] eul;
  logic signed [ZW-1:0] rz0, pz0, rzr, pzr;
  logic rflip, pflip;
  assign qs = neg_d[QW] ? -$signed({1'b0, q_c[QW]}) : $signed({1'b0, q_c[QW]});
  always_comb begin
    if (qs > (QW+1)'(8388607)) eul = 24'sh7FFFFF;
    else if (qs < -(QW+1)'(8388608)) eul = 24'sh800000;
    else eul = qs[EulW-1:0];
  end
  assign rz0 = {ra_d[QW][AngW-1], ra_d[QW], 3'b0};
  assign pz0 = {pa_d[QW][AngW-1], pa_d[QW], 3'b0};
  always_comb begin
    rflip = 1'b1; pflip = 1'b1;
    if (rz0 > Q16HalfPi) rzr = Q16Pi - rz0;
    else if (rz0 < -Q16HalfPi) rzr = -Q16Pi - rz0;
    else begin rzr = rz0; rflip = 1'b0; end
    if (pz0 > Q16HalfPi) pzr = Q16Pi - pz0;
    else if (pz0 < -Q16HalfPi) pzr = -Q16Pi - pz0;
    else begin pzr = pz0; pflip = 1'b0; end
  end

  side_t s_in;
  logic signed [XW-1:0] rx_c [NS+1], ry_c [NS+1], px_c [NS+1], py_c [NS+1];
  logic signed [ZW-1:0] rz_c [NS+1], pz_c [NS+1];
  side_t sd [NS+1];
  logic rf_d [NS+1], pf_d [NS+1];
  logic signed [ZW-1:0] rz_c0, pz_c0;
  logic rf0, pf0;
  always_ff @(posedge clk) begin
    if (en) begin
      s_in <= '{yaw: ya_d[QW], euler: eul, hi: hi_d[QW], lo: lo_d[QW]};
      rz_c0 <= rzr; pz_c0 <= pzr; rf0 <= rflip; pf0 <= pflip;
    end
  end
  assign rx_c[0] = CordicGain; assign ry_c[0] = '0; assign rz_c[0] = rz_c0;
  assign px_c[0] = CordicGain; assign py_c[0] = '0; assign pz_c[0] = pz_c0;
  assign sd[0] = s_in; assign rf_d[0] = rf0; assign pf_d[0] = pf0;
  for (genvar k = 0; k < NS; k++) begin : g_cor
    side_t s_r;
    logic rf_r, pf_r;
    parc_cordic_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(en),
      .rx_i(rx_c[k]), .ry_i(ry_c[k]), .px_i(px_c[k]), .py_i(py_c[k]),
      .rz_i(rz_c[k]), .pz_i(pz_c[k]),
      .rx_o(rx_c[k+1]), .ry_o(ry_c[k+1]), .px_o(px_c[k+1]), .py_o(py_c[k+1]),
      .rz_o(rz_c[k+1]), .pz_o(pz_c[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin s_r <= sd[k]; rf_r <= rf_d[k]; pf_r <= pf_d[k]; end
    end
    assign sd[k+1] = s_r; assign rf_d[k+1] = rf_r; assign pf_d[k+1] = pf_r;
  end

  // products: cos(roll)*euler and the coupling factor
  logic signed [XW-1:0] cr, cp;
  logic signed [2*XW-1:0] cpsr;
  logic signed [XW+EulW-1:0] p1_r;
  logic signed [2*XW-1:0] f_r;
  side_t s1_r, s2_r;
  assign cr = rf_d[NS] ? -rx_c[NS] : rx_c[NS];
  assign cp = pf_d[NS] ? -px_c[NS] : px_c[NS];
  assign cpsr = cp * ry_c[NS];
  logic signed [XW+EulW-1:0] p1b_r;
  logic signed [XW+AngW:0] p2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= cr * sd[NS].euler;
      f_r <= (cpsr + (2*XW)'(32768)) >>> 16;
      s1_r <= sd[NS];
      p1b_r <= p1_r;
      // factor stays within +-2^16, so XW signed bits hold it
      p2_r <= $signed(f_r[XW-1:0]) * s1_r.yaw;
      s2_r <= s1_r;
    end
  end

  // round, clamp, output register
  localparam int SW = XW + EulW + 1;
  logic signed [SW-1:0] sum, bdy;
  logic signed [15:0] body_r;
  logic signed [EulW-1:0] eo_r;
  logic ov_r;
  assign sum = SW'(p1b_r) + SW'(p2_r) + SW'(32768);
  assign bdy = sum >>> 16;
  always_ff @(posedge clk) begin
    if (en) begin
      if (bdy > $signed(SW'(s2_r.hi))) body_r <= 16'(s2_r.hi);
      else if (bdy < -$signed(SW'(s2_r.lo))) body_r <= -16'(s2_r.lo);
      else body_r <= bdy[15:0];
      eo_r <= s2_r.euler;
    end
  end
  assign ov_r = vld_r[NL-1];
  assign out_ch.valid = ov_r;
  assign out_ch.body_pitch_rate = body_r;
  assign out_ch.euler_pitch_rate = eo_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.body_pitch_rate))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready does not follow output register");
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r >= TcW'(RegFloor) && up_r >= LimW'(RegFloor) && dn_r >= LimW'(RegFloor))
    else $error("register below floor");
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.body_pitch_rate <= $signed({1'b0, 15'h7FFF}) &&
    out_ch.body_pitch_rate >= -16'sd32767)
    else $error("body rate out of range");
endmodule
